// ===== sv/glb_pkg.sv =====
// Shared types, constants and helpers for the greedy line breaker.
package glb_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned LenW   = 3;
  localparam int unsigned GlyphW = 8;
  localparam int unsigned PosW   = 16;
  localparam int unsigned LwW    = 24;
  localparam int unsigned LimitW = 16;
  localparam int unsigned CountW = 9;

  localparam logic [CpW-1:0] CpSpace      = CpW'(32'h20);
  localparam logic [CpW-1:0] CpLineFeed   = CpW'(32'h0a);
  localparam logic [CpW-1:0] CpAsciiEnd   = CpW'(32'h80);
  localparam logic [CpW-1:0] CpUnderscore = CpW'(32'h5f);
  localparam logic [CpW-1:0] CpApostrophe = CpW'(32'h27);

  localparam logic [LwW-1:0] WidthSat = {LwW{1'b1}};

  // configuration register indexes
  localparam logic CfgWidthLimit = 1'b0;
  localparam logic CfgMaxLines   = 1'b1;

  localparam logic [LimitW-1:0] WidthLimitRst = LimitW'(320);
  localparam logic [CountW-1:0] MaxLinesRst   = CountW'(16);

  // result queue depth; at least two so one item can push both results
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic              last_char;
    logic [GlyphW-1:0] glyph_width;
    logic [LenW-1:0]   byte_length;
    logic [CpW-1:0]    code_point;
  } item_t;

  typedef struct packed {
    logic              done_res;
    logic [CountW-1:0] line_count;
    logic [PosW-1:0]   line_start;
  } res_t;

  // up to two results per character: a new line start, then the summary
  typedef struct packed {
    logic a_vld;
    res_t a;
    logic b_vld;
    res_t b;
  } push_t;

  function automatic logic is_punct(logic [CpW-1:0] cp);
    logic alnum;
    alnum = ((cp >= CpW'(32'h61)) && (cp <= CpW'(32'h7a)))
         || ((cp >= CpW'(32'h41)) && (cp <= CpW'(32'h5a)))
         || ((cp >= CpW'(32'h30)) && (cp <= CpW'(32'h39)))
         || (cp == CpUnderscore) || (cp == CpApostrophe);
    return (cp < CpAsciiEnd) && !alnum;
  endfunction

endpackage

// ===== sv/glb_core.sv =====
// Per-character line state update and result generation.
module glb_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  glb_pkg::item_t             item_i,
  input  logic [glb_pkg::LimitW-1:0] width_limit_i,
  input  logic [glb_pkg::CountW-1:0] max_lines_i,
  output glb_pkg::push_t             push_o
);

  logic [glb_pkg::PosW-1:0]   byte_pos_q, byte_pos_d;
  logic [glb_pkg::LwW-1:0]    line_width_q, line_width_d;
  logic [glb_pkg::PosW-1:0]   break_off_q, break_off_d;
  logic [glb_pkg::LwW-1:0]    brk_width_q, brk_width_d;
  logic                       break_vld_q, break_vld_d;
  logic [glb_pkg::CountW-1:0] lines_q, lines_d;

  logic [glb_pkg::PosW-1:0]   pos_after;
  logic [glb_pkg::LwW:0]      sum;
  logic [glb_pkg::LwW-1:0]    lw;
  logic                       is_ws;
  logic                       is_lf;
  logic                       over;
  logic                       emit;
  logic                       rec;
  logic [glb_pkg::PosW-1:0]   off;
  logic [glb_pkg::CountW-1:0] lines_after;
  logic [glb_pkg::CountW-1:0] count;

  always_comb begin
    pos_after    = byte_pos_q + glb_pkg::PosW'(item_i.byte_length);
    sum          = {1'b0, line_width_q} + (glb_pkg::LwW + 1)'(item_i.glyph_width);
    lw           = sum[glb_pkg::LwW] ? glb_pkg::WidthSat : sum[glb_pkg::LwW-1:0];
    is_ws        = item_i.code_point <= glb_pkg::CpSpace;
    is_lf        = item_i.code_point == glb_pkg::CpLineFeed;
    over         = (lw > glb_pkg::LwW'(width_limit_i)) && break_vld_q;
    emit         = 1'b0;
    off          = break_off_q;
    line_width_d = line_width_q;
    break_off_d  = break_off_q;
    brk_width_d  = brk_width_q;
    break_vld_d  = break_vld_q;
    if (is_ws) begin
      if (is_lf) begin
        // line feed: a line start unless the text ends here
        off          = pos_after;
        emit         = !item_i.last_char;
        line_width_d = '0;
        break_vld_d  = 1'b0;
      end else begin
        line_width_d = lw;
        break_off_d  = pos_after;
        brk_width_d  = lw;
        break_vld_d  = 1'b1;
      end
    end else begin
      // overflow: break at the last break point, carry the tail width
      line_width_d = over ? lw - brk_width_q : lw;
      if (over) begin
        emit        = 1'b1;
        break_vld_d = 1'b0;
      end
      if (glb_pkg::is_punct(item_i.code_point)) begin
        break_off_d = pos_after;
        brk_width_d = line_width_d;
        break_vld_d = 1'b1;
      end
    end
    rec         = emit && (lines_q < max_lines_i);
    lines_after = rec ? lines_q + glb_pkg::CountW'(1) : lines_q;
    count       = (lines_after < max_lines_i) ? lines_after : max_lines_i;
    byte_pos_d  = pos_after;
    lines_d     = lines_after;
    if (item_i.last_char) begin
      byte_pos_d   = '0;
      line_width_d = '0;
      break_off_d  = '0;
      brk_width_d  = '0;
      break_vld_d  = 1'b0;
      lines_d      = glb_pkg::CountW'(1);
    end
  end

  always_comb begin
    push_o.a_vld        = fire_i && rec;
    push_o.a.line_start = off;
    push_o.a.line_count = lines_after;
    push_o.a.done_res   = 1'b0;
    push_o.b_vld        = fire_i && item_i.last_char;
    push_o.b.line_start = '0;
    push_o.b.line_count = count;
    push_o.b.done_res   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q   <= '0;
      line_width_q <= '0;
      break_off_q  <= '0;
      brk_width_q  <= '0;
      break_vld_q  <= 1'b0;
      lines_q      <= glb_pkg::CountW'(1);
    end else if (fire_i) begin
      byte_pos_q   <= byte_pos_d;
      line_width_q <= line_width_d;
      break_off_q  <= break_off_d;
      brk_width_q  <= brk_width_d;
      break_vld_q  <= break_vld_d;
      lines_q      <= lines_d;
    end
  end

`ifndef SYNTHESIS
  a_lines_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lines_q != '0) else $error("line counter reached zero");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last_char |=> byte_pos_q == '0 && lines_q == glb_pkg::CountW'(1)
      && !break_vld_q) else $error("text state not cleared after final character");

  a_line_recorded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rec && !item_i.last_char |=> lines_q == $past(lines_q) + glb_pkg::CountW'(1))
    else $error("line start emitted without count advance");
`endif

endmodule

// ===== sv/glb_fifo.sv =====
// Result queue taking up to two results per cycle, one out per cycle while ready.
module glb_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  glb_pkg::push_t            push_i,
  output logic [glb_pkg::QCntW-1:0] count_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output glb_pkg::res_t             out_data_o
);

  glb_pkg::res_t              mem [glb_pkg::QDepth];
  logic [glb_pkg::QPtrW-1:0]  wr_q, wr_d;
  logic [glb_pkg::QPtrW-1:0]  rd_q, rd_d;
  logic [glb_pkg::QCntW-1:0]  cnt_q, cnt_d;
  logic                       pop;
  logic [glb_pkg::QPtrW-1:0]  wr_b;

  assign pop         = (cnt_q != '0) && out_ready_i;
  assign wr_b        = push_i.a_vld ? wr_q + glb_pkg::QPtrW'(1) : wr_q;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem[rd_q];
  assign count_o     = cnt_q;

  always_comb begin
    wr_d  = wr_q + glb_pkg::QPtrW'(push_i.a_vld) + glb_pkg::QPtrW'(push_i.b_vld);
    rd_d  = rd_q + glb_pkg::QPtrW'(pop);
    cnt_d = cnt_q + glb_pkg::QCntW'(push_i.a_vld) + glb_pkg::QCntW'(push_i.b_vld)
          - glb_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.a_vld) begin
      mem[wr_q] <= push_i.a;
    end
    if (push_i.b_vld) begin
      mem[wr_b] <= push_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.a_vld || push_i.b_vld |-> cnt_q <= glb_pkg::QCntW'(glb_pkg::QDepth - 2))
    else $error("push into queue without room for two results");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= glb_pkg::QCntW'(glb_pkg::QDepth)) else $error("queue count beyond depth");
`endif

endmodule

// ===== sv/greedy_line_breaker.sv =====
// Greedy line breaker top level: input register, config registers, core and result queue.
// One decoded character is taken per beat (code point, byte length and glyph width in
// tdata, final character on tlast) and the block sustains one character per cycle while
// the result queue has room. Results leave one per beat: a line start (done flag low)
// when a line break is recorded, and a summary with the line count on tlast after the
// final character. The result port is the limit: a character that yields both a line
// start and the summary costs two output beats, a four-entry result queue absorbs the
// extra beat, and input stalls only while that queue cannot hold two more results.
// The user must write configuration through the cfg port only while idle (not enforced).
module greedy_line_breaker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [20:0] code_point, [23:21] byte_length, [31:24] glyph_width
  input  logic [31:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] line_start, [24:16] line_count, [31:25] zero
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  logic [glb_pkg::LimitW-1:0] width_limit_q;
  logic [glb_pkg::CountW-1:0] max_lines_q;
  glb_pkg::item_t             in_q;
  logic                       in_vld_q;
  logic                       room;
  logic                       fire;
  logic                       take;
  logic [glb_pkg::QCntW-1:0]  q_count;
  glb_pkg::push_t             push;
  glb_pkg::res_t              res;

  assign cfg_ready_o     = 1'b1;
  assign room            = q_count <= glb_pkg::QCntW'(glb_pkg::QDepth - 2);
  assign fire            = in_vld_q && room;
  assign s_axis_tready_o = !in_vld_q || room;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_limit_q <= glb_pkg::WidthLimitRst;
      max_lines_q   <= glb_pkg::MaxLinesRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        glb_pkg::CfgWidthLimit: width_limit_q <= cfg_data_i;
        glb_pkg::CfgMaxLines:   max_lines_q   <= cfg_data_i[glb_pkg::CountW-1:0];
        default:                width_limit_q <= width_limit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  // hold the beat until the core consumes it
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q.code_point  <= s_axis_tdata_i[20:0];
      in_q.byte_length <= s_axis_tdata_i[23:21];
      in_q.glyph_width <= s_axis_tdata_i[31:24];
      in_q.last_char   <= s_axis_tlast_i;
    end
  end

  glb_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (in_q),
    .width_limit_i (width_limit_q),
    .max_lines_i   (max_lines_q),
    .push_o        (push)
  );

  glb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .count_o     (q_count),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res)
  );

  assign m_axis_tdata_o = {7'b0, res.line_count, res.line_start};
  assign m_axis_tlast_o = res.done_res;

endmodule

// ===== tb/sv/line_break_board.sv =====
// Scoreboard class for the greedy line breaker: predicts line starts and text summaries.
`timescale 1ns / 100ps
package line_break_board_pkg;
  import glb_pkg::*;

  class line_break_board;
    logic [LimitW-1:0] width_limit;
    logic [CountW-1:0] max_lines;

    logic [PosW-1:0]   byte_pos;
    logic [LwW-1:0]    line_w;
    logic [PosW-1:0]   brk_off;
    logic [LwW-1:0]    w_at_brk;
    logic              brk_ok;
    logic [CountW-1:0] lines;

    res_t line_q[$];
    int   errors;

    function new();
      width_limit = WidthLimitRst;
      max_lines   = MaxLinesRst;
      errors      = 0;
      clear_text();
    endfunction

    function void clear_text();
      byte_pos = '0;
      line_w   = '0;
      brk_off  = '0;
      w_at_brk = '0;
      brk_ok   = 1'b0;
      lines    = CountW'(1);
    endfunction

    // ASCII punctuation ends a word; letters, digits, underscore, apostrophe do not
    static function logic is_break_char(logic [CpW-1:0] cp);
      if (cp >= CpAsciiEnd) return 1'b0;
      if (cp inside {[21'h61:21'h7a], [21'h41:21'h5a], [21'h30:21'h39],
                     CpUnderscore, CpApostrophe}) return 1'b0;
      return 1'b1;
    endfunction

    function void set_reg(logic idx, logic [15:0] data);
      if (idx == CfgWidthLimit) width_limit = data;
      else max_lines = data[CountW-1:0];
    endfunction

    function int pending();
      return line_q.size();
    endfunction

    function void note_char(item_t it);
      logic [PosW-1:0] pos_after;
      logic [PosW-1:0] off;
      logic [LwW:0]    sum;
      logic [LwW-1:0]  lw;
      logic            emit;
      res_t            r;

      pos_after = byte_pos + PosW'(it.byte_length);
      sum       = line_w + it.glyph_width;
      lw        = sum[LwW] ? WidthSat : sum[LwW-1:0];
      emit      = 1'b0;
      off       = '0;

      if (it.code_point <= CpSpace) begin
        if (it.code_point == CpLineFeed) begin
          // a line feed on the final character opens no new line
          off    = pos_after;
          emit   = !it.last_char;
          line_w = '0;
          brk_ok = 1'b0;
        end else begin
          line_w   = lw;
          brk_off  = pos_after;
          w_at_brk = lw;
          brk_ok   = 1'b1;
        end
      end else begin
        if (lw > LwW'(width_limit) && brk_ok) begin
          // carry the width measured since the break into the new line
          off    = brk_off;
          emit   = 1'b1;
          lw     = lw - w_at_brk;
          brk_ok = 1'b0;
        end
        line_w = lw;
        if (is_break_char(it.code_point)) begin
          brk_off  = pos_after;
          w_at_brk = lw;
          brk_ok   = 1'b1;
        end
      end
      byte_pos = pos_after;

      if (emit && lines < max_lines) begin
        lines        = lines + 1'b1;
        r.line_start = off;
        r.line_count = lines;
        r.done_res   = 1'b0;
        line_q.push_back(r);
      end

      if (it.last_char) begin
        r.line_start = '0;
        r.line_count = (lines < max_lines) ? lines : max_lines;
        r.done_res   = 1'b1;
        line_q.push_back(r);
        clear_text();
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (line_q.size() == 0) begin
        $error("unexpected beat: line_start %0d line_count %0d done_res %0b",
               got.line_start, got.line_count, got.done_res);
        errors++;
        return;
      end
      want = line_q.pop_front();
      if (got.line_start !== want.line_start) begin
        $error("line_start: expected %0d, got %0d", want.line_start, got.line_start);
        errors++;
      end
      if (got.line_count !== want.line_count) begin
        $error("line_count: expected %0d, got %0d", want.line_count, got.line_count);
        errors++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level testbench for the greedy line breaker: stream drivers, config writes, checking.
`timescale 1ns / 100ps
module tb_top;
  import glb_pkg::*;
  import line_break_board_pkg::*;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic [31:0] s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tready  = 1'b0;
  logic        cfg_ready;
  logic        s_tready;
  logic        m_tvalid;
  logic [31:0] m_tdata;
  logic        m_tlast;

  // no random idling on either side while set
  bit quiet = 1'b0;

  line_break_board board = new();

  greedy_line_breaker dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always #6 clk = ~clk;

  // check each result beat, then decide the next cycle's ready
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready)
      board.check_result(res_t'({m_tlast, m_tdata[24:16], m_tdata[15:0]}));
    m_tready <= rst_n && (quiet || $urandom_range(99) >= 8);
  end

  task automatic send_char(input item_t it);
    while (!quiet && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.glyph_width, it.byte_length, it.code_point};
    s_tlast  <= it.last_char;
    do @(posedge clk); while (!s_tready);
    board.note_char(it);
  endtask

  task automatic put_char(input logic [CpW-1:0] cp, input logic [LenW-1:0] len,
                          input logic [GlyphW-1:0] gw, input logic last);
    item_t it;
    it.code_point  = cp;
    it.byte_length = len;
    it.glyph_width = gw;
    it.last_char   = last;
    send_char(it);
  endtask

  // hold the sender until every expected line has come out; settle before config writes
  task automatic wait_idle(input bit settle);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    if (settle) repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [LimitW-1:0] limit, input logic [CountW-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_index <= CfgWidthLimit;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(CfgWidthLimit, limit);
    cfg_index <= CfgMaxLines;
    cfg_data  <= 16'(cap);
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(CfgMaxLines, 16'(cap));
    cfg_valid <= 1'b0;
  endtask

  function automatic item_t make_char();
    item_t       c;
    int unsigned pick;
    pick          = $urandom_range(99);
    c.last_char   = 1'b0;
    c.byte_length = LenW'(1);
    c.glyph_width = GlyphW'($urandom_range(16, 4));
    if ($urandom_range(19) == 0) c.glyph_width = $urandom_range(1) ? 8'hff : 8'h00;
    if (pick < 55) begin
      case ($urandom_range(5))
        0, 1: c.code_point = CpW'($urandom_range(8'h7a, 8'h61));
        2:    c.code_point = CpW'($urandom_range(8'h5a, 8'h41));
        3:    c.code_point = CpW'($urandom_range(8'h39, 8'h30));
        4:    c.code_point = CpUnderscore;
        default: c.code_point = CpApostrophe;
      endcase
    end else if (pick < 70) begin
      c.code_point = ($urandom_range(3) == 0) ? CpW'($urandom_range(8'h20)) : CpSpace;
    end else if (pick < 78) begin
      do c.code_point = CpW'($urandom_range(8'h7f, 8'h21));
      while (!line_break_board::is_break_char(c.code_point));
    end else if (pick < 82) begin
      c.code_point = CpLineFeed;
    end else if (pick < 94) begin
      c.code_point  = CpW'($urandom_range(21'h10ffff, 21'h80));
      c.byte_length = LenW'($urandom_range(4, 2));
    end else begin
      // raw noise: any codepoint, any byte length, any width
      c.code_point  = CpW'($urandom);
      c.byte_length = LenW'($urandom);
      c.glyph_width = GlyphW'($urandom);
    end
    return c;
  endfunction

  task automatic send_text(input int unsigned n_chars);
    item_t c;
    for (int unsigned k = 1; k <= n_chars; k++) begin
      c           = make_char();
      c.last_char = (k == n_chars);
      if (!quiet && $urandom_range(199) == 0) wait_idle(1'b0);
      send_char(c);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // breaks after space, punctuation and NUL, line feeds, odd lengths, wide glyphs
    set_config(16'd20, 9'd16);
    put_char(21'h61, 3'd1, 8'd8, 1'b0);
    put_char(21'h62, 3'd1, 8'd8, 1'b0);
    put_char(CpSpace, 3'd1, 8'd4, 1'b0);
    put_char(21'h63, 3'd1, 8'd8, 1'b0);
    put_char(21'h2d, 3'd1, 8'd4, 1'b0);
    put_char(21'h1fffff, 3'd7, 8'd255, 1'b0);
    put_char(CpLineFeed, 3'd1, 8'd0, 1'b0);
    put_char(21'h10ffff, 3'd4, 8'd10, 1'b0);
    put_char(21'h0, 3'd0, 8'd0, 1'b0);
    put_char(CpUnderscore, 3'd1, 8'd30, 1'b0);
    put_char(CpApostrophe, 3'd1, 8'd5, 1'b0);
    put_char(CpLineFeed, 3'd1, 8'd0, 1'b1);
    put_char(21'h78, 3'd1, 8'd255, 1'b1);

    // shrink the capacity mid-text: summary count drops to the new cap
    put_char(CpSpace, 3'd1, 8'd1, 1'b0);
    put_char(21'h61, 3'd1, 8'd30, 1'b0);
    put_char(CpSpace, 3'd2, 8'd1, 1'b0);
    put_char(21'h62, 3'd1, 8'd30, 1'b0);
    wait_idle(1'b1);
    set_config(16'd0, 9'd1);
    put_char(21'h2e, 3'd5, 8'd1, 1'b1);

    wait_idle(1'b1);
    set_config(16'd0, 9'd0);
    put_char(CpSpace, 3'd6, 8'd3, 1'b1);

    // cap reached: the second break is dropped
    wait_idle(1'b1);
    set_config(16'd0, 9'd2);
    put_char(CpSpace, 3'd1, 8'd0, 1'b0);
    put_char(21'h61, 3'd1, 8'd1, 1'b0);
    put_char(CpSpace, 3'd1, 8'd0, 1'b0);
    put_char(21'h62, 3'd1, 8'd1, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle(1'b1);
      case (ph)
        0: set_config(16'd320, 9'd16);
        1: set_config(16'd0, 9'd256);
        2: set_config(16'hffff, 9'd1);
        3: set_config(16'($urandom_range(120, 20)), 9'd511);
        4: set_config(16'($urandom_range(200, 40)), 9'd2);
        5: set_config(16'($urandom), 9'($urandom_range(8, 1)));
        6: set_config(16'($urandom_range(60, 10)), 9'd256);
        default: set_config(16'($urandom_range(400, 100)), 9'd0);
      endcase
      quiet = (ph == 0);
      sent  = 0;
      while (sent < 200) begin
        n = $urandom_range(60, 1);
        send_text(n);
        sent += n;
      end
    end
    quiet = 1'b0;

    wait_idle(1'b1);
    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/glb_pkg.sv
sv/glb_core.sv
sv/glb_fifo.sv
sv/greedy_line_breaker.sv
tb/sv/line_break_board.sv
tb/sv/tb_top.sv
